// ===== design/bsf_pkg.sv =====
// Package for the beacon SSID filter: payload structs, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package bsf_pkg;

   localparam int TABLE_DEPTH    = 32;
   localparam int MAX_SSID_BYTES = 32;
   localparam int IDX_W          = $clog2(TABLE_DEPTH);
   localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IGNORED   = 3'd0;
   localparam logic [2:0] ST_NO_MATCH  = 3'd1;
   localparam logic [2:0] ST_KNOWN     = 3'd2;
   localparam logic [2:0] ST_ADDED     = 3'd3;
   localparam logic [2:0] ST_MALFORMED = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [2:0] CSR_SSID_LEN = 3'd0;
   localparam logic [2:0] CSR_SSID_B0  = 3'd1;
   localparam logic [2:0] CSR_SSID_B3  = 3'd4;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] bss_address;
      logic [4:0]  entry_index;
      logic [5:0]  entry_count;
   } rsp_type;

   // Search token handed from cell to cell down the table chain
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] index;
      logic [47:0]      addr;
      logic [2:0]       status;
   } probe_type;

endpackage

// ===== design/bsf_cell.sv =====
// One table slot of the BSS chain: holds an address, compares the passing probe.
// Depends on bsf_pkg.
`timescale 1ns / 1ps
module bsf_cell
   import bsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] slot,
   input  logic [CNT_W-1:0] count,
   input  logic             write,
   input  logic [47:0]      wdata,
   input  probe_type        probe_i,
   output probe_type        probe_o
);
   logic [47:0] addr_ff;
   logic        hit;
   probe_type   probe_ff, probe_in;

   // slot stores the address when the tail adds it
   always_ff @(posedge clock) begin
      if (write) addr_ff <= wdata;
   end

   assign hit = probe_i.valid && !probe_i.found &&
                ({1'b0, slot} < count) && (addr_ff == probe_i.addr);

   always_comb begin
      probe_in = probe_i;
      if (hit) begin
         probe_in.found = 1'b1;
         probe_in.index = slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) probe_ff.valid <= 1'b0;
      else probe_ff.valid <= probe_in.valid;
      probe_ff.found  <= probe_in.found;
      probe_ff.index  <= probe_in.index;
      probe_ff.addr   <= probe_in.addr;
      probe_ff.status <= probe_in.status;
   end
   assign probe_o = probe_ff;
endmodule

// ===== design/bsf_parser.sv =====
// Per-byte frame parser: header capture, FCS delay line, element walk, SSID compare.
// Depends on bsf_pkg.
`timescale 1ns / 1ps
module bsf_parser
   import bsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic [5:0]  ssid_length,
   input  logic [255:0] ssid_bytes,
   output logic        frame_end,
   output logic [2:0]  pre_status,
   output logic [47:0] addr
);
   logic [11:0] pos_ff, pos_in;
   logic        beacon_ff, beacon_in;
   logic [47:0] sa_ff, sa_in;
   logic [7:0]  dl_ff [4];
   logic [1:0]  ph_ff, ph_in;
   logic        ssid_ff, ssid_in;
   logic [7:0]  left_ff, left_in;
   logic [5:0]  ci_ff, ci_in;
   logic        ok_ff, ok_in;
   logic        match_ff, match_in;
   logic [7:0]  b, eb, want;
   logic [7:0]  left_dec;

   assign b = req.frame_byte;
   assign eb = dl_ff[3];
   assign want = ssid_bytes[{ci_ff[4:0], 3'b000} +: 8];
   assign left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;

   // next-state for one accepted byte
   always_comb begin
      pos_in = (pos_ff != 12'hFFF) ? pos_ff + 12'd1 : pos_ff;
      beacon_in = (pos_ff == 12'd0) ? (b == 8'h80) : beacon_ff;
      sa_in = sa_ff;
      if (pos_ff >= 12'd10 && pos_ff <= 12'd15)
         sa_in[{pos_ff[2:0] - 3'd2, 3'b000} +: 8] = b;
      ph_in = ph_ff; ssid_in = ssid_ff; left_in = left_ff;
      ci_in = ci_ff; ok_in = ok_ff; match_in = match_ff;
      if (beacon_in && pos_ff >= 12'd40) begin
         case (ph_ff)
            2'd0: begin
               ssid_in = (eb == 8'd0);
               ph_in = 2'd1;
            end
            2'd1: begin
               left_in = eb;
               ci_in = 6'd0;
               ok_in = ({2'b00, ssid_length} == eb) && (ssid_length <= 6'(MAX_SSID_BYTES));
               if (eb == 8'd0) begin
                  ph_in = 2'd0;
                  if (ssid_ff && ok_in) match_in = 1'b1;
               end else ph_in = 2'd2;
            end
            default: begin
               if (ssid_ff && ok_ff) begin
                  if (ci_ff < ssid_length && eb != want) ok_in = 1'b0;
                  if (ci_ff < 6'd63) ci_in = ci_ff + 6'd1;
               end
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  ph_in = 2'd0;
                  if (ssid_ff && ok_in) match_in = 1'b1;
               end
            end
         endcase
      end
   end

   // frame-end classification, before the table lookup
   always_comb begin
      frame_end = accept && req.last_byte;
      addr = sa_in;
      if (pos_ff < 12'd23 || !beacon_in) begin
         pre_status = ST_IGNORED;
         addr = 48'd0;
      end else if (pos_ff < 12'd39 || ph_in != 2'd0) pre_status = ST_MALFORMED;
      else if (!match_in) pre_status = ST_NO_MATCH;
      else pre_status = ST_KNOWN;   // table lookup decides known/added/full
   end

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         pos_ff <= '0; beacon_ff <= 1'b0; sa_ff <= '0; ph_ff <= '0;
         ssid_ff <= 1'b0; left_ff <= '0; ci_ff <= '0; ok_ff <= 1'b0;
         match_ff <= 1'b0;
         for (int i = 0; i < 4; i++) dl_ff[i] <= 8'd0;
      end else if (accept) begin
         pos_ff <= pos_in; beacon_ff <= beacon_in; sa_ff <= sa_in; ph_ff <= ph_in;
         ssid_ff <= ssid_in; left_ff <= left_in; ci_ff <= ci_in; ok_ff <= ok_in;
         match_ff <= match_in;
         dl_ff[0] <= b;
         for (int i = 1; i < 4; i++) dl_ff[i] <= dl_ff[i-1];
      end
   end
endmodule

// ===== design/beacon_ssid_filter_bss_table_core.sv =====
// Top level of the beacon SSID filter with a chained BSS address table.
// Bytes other than the last are taken at one per cycle with no result while
// no probe or result is pending. A frame end sends a probe down TABLE_DEPTH
// table cells, one per cycle; its result is registered from the chain tail, and
// no byte is taken while a probe or an untaken result is pending. Synchronous reset
// empties the table (count zero) and clears all frame and config state.
`timescale 1ns / 1ps
module beacon_ssid_filter_bss_table_core
   import bsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   logic [5:0]   len_ff;
   logic [255:0] ssid_ff;
   logic         busy_ff, busy_in;
   logic         accept, frame_end;
   logic [2:0]   pre_status;
   logic [47:0]  addr;
   logic [CNT_W-1:0] count_ff;
   probe_type    chain [TABLE_DEPTH+1];
   probe_type    tail;
   logic         add;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; ssid_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_SSID_LEN) len_ff <= csr_data[5:0];
         else if (csr_index >= CSR_SSID_B0 && csr_index <= CSR_SSID_B3)
            ssid_ff[{csr_index[1:0] - 2'd1, 6'd0} +: 64] <= csr_data;
      end
   end

   assign req_stall = busy_ff || rsp_valid_ff;
   assign accept = req_valid && !req_stall;

   bsf_parser u_parser (
      .clock, .reset, .accept, .req(req_data),
      .ssid_length(len_ff), .ssid_bytes(ssid_ff),
      .frame_end, .pre_status, .addr
   );

   // probe enters the chain at every frame end
   always_comb begin
      chain[0].valid  = frame_end;
      chain[0].found  = 1'b0;
      chain[0].index  = '0;
      chain[0].addr   = addr;
      chain[0].status = pre_status;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      bsf_cell u_cell (
         .clock, .reset,
         .slot(IDX_W'(g)), .count(count_ff),
         .write(add && (count_ff == CNT_W'(g))),
         .wdata(tail.addr),
         .probe_i(g == 0 ? chain[0] : chain[g]),
         .probe_o(chain[g+1])
      );
   end

   assign tail = chain[TABLE_DEPTH];
   assign add = tail.valid && tail.status == ST_KNOWN && !tail.found &&
                count_ff < CNT_W'(TABLE_DEPTH);

   // a new address is written into the next free cell from the chain tail
   assign busy_in = frame_end ? 1'b1 : (tail.valid ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; count_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (add) count_ff <= count_ff + CNT_W'(1);
         if (tail.valid) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff.bss_address <= tail.addr;
         rsp_ff.entry_index <= 5'd0;
         rsp_ff.entry_count <= 6'(count_ff) + (add ? 6'd1 : 6'd0);
         if (tail.status != ST_KNOWN) rsp_ff.status <= tail.status;
         else if (tail.found) begin
            rsp_ff.status <= ST_KNOWN;
            rsp_ff.entry_index <= 5'(tail.index);
         end else if (add) begin
            rsp_ff.status <= ST_ADDED;
            rsp_ff.entry_index <= 5'(count_ff);
         end else rsp_ff.status <= ST_FULL;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== tb/sv/beacon_ssid_filter_bss_table_core_tb.sv =====
// Testbench for beacon_ssid_filter_bss_table_core: drives frame bytes with random
// idling, predicts one response per frame end and checks it in order.
// Depends on bsf_pkg and the core RTL.
`timescale 1ns / 1ps
import bsf_pkg::*;

// Predicts the per-frame response and checks responses in order
class bss_scoreboard;

   bit [5:0]   ssid_len;
   bit [63:0]  ssid_words [4];
   int         pos;
   bit         beacon;
   bit [47:0]  sender;
   bit [7:0]   dly [4];
   bit [1:0]   phase;
   bit         is_ssid;
   bit [7:0]   left;
   bit [5:0]   cmp_idx;
   bit         cmp_ok;
   bit         matched;
   bit [47:0]  bss_list [$];
   rsp_type    expected_q [$];
   int         errors;

   function void write_csr(bit [2:0] idx, bit [63:0] data);
      if (idx == CSR_SSID_LEN) ssid_len = data[5:0];
      else if (idx >= CSR_SSID_B0 && idx <= CSR_SSID_B3) ssid_words[idx - CSR_SSID_B0] = data;
   endfunction

   function bit [7:0] wanted(bit [5:0] i);
      return ssid_words[i[4:3]][i[2:0] * 8 +: 8];
   endfunction

   function void clear_frame();
      pos = 0; beacon = 0; sender = '0;
      foreach (dly[i]) dly[i] = '0;
      phase = 0; is_ssid = 0; left = 0; cmp_idx = 0; cmp_ok = 0; matched = 0;
   endfunction

   function void element_done();
      phase = 0;
      if (is_ssid && cmp_ok) matched = 1;
   endfunction

   // Element walk: id, length, then body bytes
   function void walk_element(bit [7:0] b);
      if (phase == 0) begin
         is_ssid = (b == 0);
         phase = 1;
      end else if (phase == 1) begin
         left = b;
         cmp_idx = 0;
         cmp_ok = (b == ssid_len) && (ssid_len <= MAX_SSID_BYTES);
         if (b == 0) element_done();
         else phase = 2;
      end else begin
         if (is_ssid && cmp_ok) begin
            if (cmp_idx < ssid_len && b != wanted(cmp_idx)) cmp_ok = 0;
            if (cmp_idx < 63) cmp_idx++;
         end
         if (left > 0) left--;
         if (left == 0) element_done();
      end
   endfunction

   function void note_request(req_type r);
      rsp_type e;
      int p;
      bit found;
      p = pos;
      e = '0;
      if (p == 0) beacon = (r.frame_byte == 8'h80);
      if (p >= 10 && p <= 15) sender[(p - 10) * 8 +: 8] = r.frame_byte;
      if (beacon && p >= 40) walk_element(dly[3]);
      dly[3] = dly[2]; dly[2] = dly[1]; dly[1] = dly[0]; dly[0] = r.frame_byte;
      if (!r.last_byte) begin
         if (pos < 4095) pos++;
         return;
      end
      // frame length is p + 1
      if (p + 1 < 24 || !beacon) begin
         e.status = ST_IGNORED;
      end else begin
         e.bss_address = sender;
         if (p + 1 < 40 || phase != 0) e.status = ST_MALFORMED;
         else if (!matched) e.status = ST_NO_MATCH;
         else begin
            found = 0;
            foreach (bss_list[i])
               if (!found && bss_list[i] == sender) begin
                  found = 1;
                  e.entry_index = 5'(i);
               end
            if (found) e.status = ST_KNOWN;
            else if (bss_list.size() >= TABLE_DEPTH) e.status = ST_FULL;
            else begin
               e.entry_index = 5'(bss_list.size());
               bss_list.push_back(sender);
               e.status = ST_ADDED;
            end
         end
      end
      e.entry_count = 6'(bss_list.size());
      expected_q.push_back(e);
      clear_frame();
   endfunction

   function void report(string name, bit [47:0] exp_v, bit [47:0] act_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
   endfunction

   function void check_response(rsp_type r);
      rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected response, actual %0h", $time, r);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (r.status != e.status) report("status", e.status, r.status);
      if (r.bss_address != e.bss_address) report("bss_address", e.bss_address, r.bss_address);
      if (r.entry_index != e.entry_index) report("entry_index", e.entry_index, r.entry_index);
      if (r.entry_count != e.entry_count) report("entry_count", e.entry_count, r.entry_count);
   endfunction
endclass

module beacon_ssid_filter_bss_table_core_tb;
   import bsf_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_type      req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1;
   rsp_type      rsp_data;
   logic         csr_write = 0;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   bss_scoreboard sb = new();
   bit [7:0]   frame_q [$];
   bit [47:0]  addr_pool [40];
   bit         req_busy_run;
   bit         rsp_busy_run;
   bit         hold_req;
   int         sent_bytes;
   int         frames_done;

   beacon_ssid_filter_bss_table_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stall per response, one long hold on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = rsp_busy_run ? 0 : $urandom_range(0, 13);
         if (hold_req) begin
            n = 400;
            hold_req = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

   task automatic send_byte(bit [7:0] b, bit last);
      int gap;
      gap = req_busy_run ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{frame_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
      sb.note_request('{frame_byte: b, last_byte: last});
      sent_bytes++;
   endtask

   task automatic send_frame();
      req_busy_run = ($urandom_range(0, 3) == 0);
      rsp_busy_run = ($urandom_range(0, 3) == 0);
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frames_done++;
   endtask

   // Stop offering requests until every response is in, then let the block settle
   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(bit [5:0] len);
      bit [63:0] d;
      for (int i = 0; i <= 5; i++) begin
         d = {$urandom, $urandom};
         if (i == 0) d = {$urandom, 26'(0), len};
         csr_write <= 1;
         csr_index <= (i == 5) ? 3'($urandom_range(5, 7)) : 3'(i);
         csr_data <= d;
         @(posedge clock);
         sb.write_csr((i == 5) ? 3'd5 : 3'(i), d);
      end
      csr_write <= 0;
   endtask

   // Header of a beacon (or other frame when first byte differs) from a sender
   task automatic put_header(bit [7:0] fc, bit [47:0] addr);
      frame_q = {};
      frame_q.push_back(fc);
      for (int i = 1; i < 36; i++)
         frame_q.push_back((i >= 10 && i <= 15) ? addr[(i - 10) * 8 +: 8] : 8'($urandom));
   endtask

   task automatic put_ssid(bit good);
      int n;
      int k;
      k = $urandom_range(0, 2);
      n = good ? sb.ssid_len : $urandom_range(0, 33);
      frame_q.push_back((!good && k == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      frame_q.push_back(8'(n));
      for (int i = 0; i < n; i++) frame_q.push_back(sb.wanted(6'(i)));
      // wrong content: one byte flipped or all bytes random
      if (!good && k == 1 && n > 0) frame_q[frame_q.size() - 1 - $urandom_range(0, n - 1)] ^= 8'h01;
      else if (!good && k == 2)
         for (int i = 0; i < n; i++) frame_q[frame_q.size() - 1 - i] = 8'($urandom);
   endtask

   task automatic put_other_elements(int cnt, int max_len);
      int n;
      for (int j = 0; j < cnt; j++) begin
         n = $urandom_range(0, max_len);
         frame_q.push_back(8'($urandom_range(1, 255)));
         frame_q.push_back(8'(n));
         for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
      end
   endtask

   task automatic put_fcs();
      repeat (4) frame_q.push_back(8'($urandom));
   endtask

   task automatic build_beacon(bit good, bit broken);
      bit [47:0] a;
      a = ($urandom_range(0, 9) < 6) ? addr_pool[$urandom_range(0, 39)]
                                     : {16'($urandom), 32'($urandom)};
      put_header(8'h80, a);
      put_other_elements($urandom_range(0, 2), 6);
      put_ssid(good);
      put_other_elements($urandom_range(0, 1), 6);
      if (broken) begin
         if ($urandom_range(0, 1) && frame_q.size() > 37)
            repeat ($urandom_range(1, 2)) void'(frame_q.pop_back());
         else
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end
      put_fcs();
   endtask

   task automatic build_noise(int len, bit [7:0] fc);
      frame_q = {};
      frame_q.push_back(fc);
      for (int i = 1; i < len; i++) frame_q.push_back(8'($urandom));
   endtask

   task automatic random_frame();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) build_noise($urandom_range(1, 23), $urandom_range(0, 1) ? 8'h80 : 8'($urandom));
      else if (r < 14) build_noise($urandom_range(24, 39), 8'h80);
      else if (r < 20) begin
         build_beacon(1, 0);
         frame_q[0] = $urandom_range(0, 1) ? 8'h81 : 8'($urandom_range(0, 127));
      end else if (r < 30) build_beacon($urandom_range(0, 1), 1);
      else if (r < 45) build_beacon(0, 0);
      else build_beacon(1, 0);
      send_frame();
   endtask

   initial begin
      bit [5:0] lens [6];
      int results_goal;
      foreach (addr_pool[i]) addr_pool[i] = {16'($urandom), 32'($urandom)};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: tiny frame, too-short beacon, truncated beacon, and minimal
      // beacons with empty SSID from an all-ones address and twice from address zero
      write_regs(0);
      build_noise(1, 8'hFF); send_frame();
      build_noise(23, 8'h80); send_frame();
      build_noise(24, 8'h80); send_frame();
      put_header(8'h80, 48'hFFFF_FFFF_FFFF); put_ssid(1); put_fcs(); send_frame();
      put_header(8'h80, 48'h0); put_ssid(1); put_fcs(); send_frame();
      put_header(8'h80, 48'h0); put_ssid(1); put_fcs(); send_frame();

      // Random phases over several SSID settings, extremes included
      lens = '{6'd5, 6'd32, 6'd0, 6'd63, 6'($urandom_range(1, 31)), 6'd32};
      foreach (lens[ph]) begin
         wait_idle();
         write_regs(lens[ph]);
         results_goal = frames_done + 3;
         if (ph == 2) hold_req = 1;
         while (sent_bytes < 200 * (ph + 1) || frames_done < results_goal)
            random_frame();
         // one beacon with an element of up to 255 bytes ahead of the SSID
         if (ph == 1) begin
            put_header(8'h80, addr_pool[0]);
            put_other_elements(1, 255);
            put_ssid(1);
            put_fcs();
            send_frame();
         end
      end

      wait_idle();
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
